// ===== sv/u8ld_pkg.sv =====
// shared types, constants and decode helpers for the lenient utf-8 decoder
`timescale 1ns / 1ps

package u8ld_pkg;

  // lead byte classes
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_MATCH = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_MATCH = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_MATCH = 8'hF0;

  // payload bit masks
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD4_BITS = 8'h07;
  localparam logic [7:0] CONT_BITS  = 8'h3F;

  localparam int PEND_DEPTH = 3;
  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       text_end;
  } in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [15:0] begin_offset;
    logic [16:0] end_offset;
    logic        last_of_run;
    logic        offset_overflow;
  } out_t;

  // buffered part of an unfinished sequence
  typedef struct packed {
    logic [PEND_DEPTH-1:0][7:0] bytes;
    logic [1:0]                 count;
    logic [2:0]                 need;
  } pend_t;

  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd1;
    if ((c & LEAD2_MASK) == LEAD2_MATCH) begin
      len = 3'd2;
    end else if ((c & LEAD3_MASK) == LEAD3_MATCH) begin
      len = 3'd3;
    end else if ((c & LEAD4_MASK) == LEAD4_MATCH) begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [20:0] seq_value(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3,
                                            input logic [2:0] len);
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [7:0]  c3;
    logic [20:0] v;
    c1 = b1 & CONT_BITS;
    c2 = b2 & CONT_BITS;
    c3 = b3 & CONT_BITS;
    case (len)
      3'd2: begin
        c0 = b0 & LEAD2_BITS;
        v  = {10'd0, c0[4:0], c1[5:0]};
      end
      3'd3: begin
        c0 = b0 & LEAD3_BITS;
        v  = {5'd0, c0[3:0], c1[5:0], c2[5:0]};
      end
      3'd4: begin
        c0 = b0 & LEAD4_BITS;
        v  = {c0[2:0], c1[5:0], c2[5:0], c3[5:0]};
      end
      default: begin
        c0 = b0;
        v  = {13'd0, b0};
      end
    endcase
    return v;
  endfunction

endpackage

// ===== sv/utf8_lenient_decoder.sv =====
// top level of the lenient utf-8 decoder
`timescale 1ns / 1ps

// takes one text byte per cycle and returns one code point transaction per
// sequence, with its begin and end byte offsets. lead bytes 110, 1110 and
// 11110 gather the next one, two or three bytes without checking them; any
// other byte passes through as itself. when a text ends inside a sequence,
// the lead byte comes out raw and the bytes behind it are decoded again, so
// the last byte can yield up to three transactions. a new byte is taken every
// cycle as long as the result queue holds at most one transaction; results
// are registered in the queue and leave at one per cycle unless cp_stall is
// high; with no output stall only a text-end flush can stall input. offsets
// saturate past MAX_TEXT_BYTES; offset_overflow is raised until text end.
module utf8_lenient_decoder #(
  parameter int MAX_TEXT_BYTES = 65536
) (
  input  logic           clk,
  input  logic           rst,
  // byte stream
  input  logic           src_valid,
  output logic           src_stall,
  input  u8ld_pkg::in_t  src_data,
  // code point stream
  output logic           cp_valid,
  input  logic           cp_stall,
  output u8ld_pkg::out_t cp_data
);
  import u8ld_pkg::*;

  // position counter must hold MAX_TEXT_BYTES itself
  localparam int PW = $clog2(MAX_TEXT_BYTES + 1);

  // decoder state
  pend_t         pend;
  logic [PW-1:0] position;
  logic          overflow;

  pend_t         pend_next;
  logic [PW-1:0] position_next;
  logic          overflow_next;

  logic                        room;
  logic                        accept;
  logic [1:0]                  res_count;
  out_t [MAX_RESULTS-1:0]      res;

  // stall input only when a flush might not fit in the queue
  assign src_stall = !room;
  assign accept    = src_valid && room;

  u8ld_decode #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES),
    .PW            (PW)
  ) u_decode (
    .item         (src_data),
    .pend         (pend),
    .position     (position),
    .overflow     (overflow),
    .pend_next    (pend_next),
    .position_next(position_next),
    .overflow_next(overflow_next),
    .res_count    (res_count),
    .res          (res)
  );

  // state advances once per accepted byte transaction; buffered bytes are
  // payload, read only after being written, so reset leaves them alone
  always_ff @(posedge clk) begin
    if (rst) begin
      pend.count <= 2'd0;
      pend.need  <= 3'd0;
      position   <= '0;
      overflow   <= 1'b0;
    end else if (accept) begin
      pend       <= pend_next;
      position   <= position_next;
      overflow   <= overflow_next;
    end
  end

  u8ld_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_count(accept ? res_count : 2'd0),
    .push_data (res),
    .room      (room),
    .out_valid (cp_valid),
    .out_stall (cp_stall),
    .out_data  (cp_data)
  );

endmodule

// ===== sv/u8ld_decode.sv =====
// one-byte decode step: buffers a sequence or splits it into code points
`timescale 1ns / 1ps

module u8ld_decode #(
  parameter int MAX_TEXT_BYTES = 65536,
  parameter int PW             = 17
) (
  input  u8ld_pkg::in_t                        item,
  input  u8ld_pkg::pend_t                      pend,
  input  logic [PW-1:0]                        position,
  input  logic                                 overflow,
  output u8ld_pkg::pend_t                      pend_next,
  output logic [PW-1:0]                        position_next,
  output logic                                 overflow_next,
  output logic [1:0]                           res_count,
  output u8ld_pkg::out_t [u8ld_pkg::MAX_RESULTS-1:0] res
);
  import u8ld_pkg::*;

  localparam logic [PW-1:0] MAX_POS   = PW'(MAX_TEXT_BYTES);
  localparam logic [PW:0]   MAX_END   = (PW+1)'(MAX_TEXT_BYTES);
  localparam logic [PW-1:0] MAX_BEGIN = PW'(MAX_TEXT_BYTES - 1);

  always_comb begin
    logic              at_max;
    logic [PW-1:0]     idx;
    logic              ovf_now;
    logic [2:0]        n;
    logic [2:0]        need;
    logic              hold;
    logic [7:0]        bufx [8];
    logic [PW-1:0]     offs [8];
    logic [2:0]        back;
    logic [2:0]        st;
    logic [2:0]        len;
    logic              ok;
    logic [PW-1:0]     b;
    logic [PW:0]       e;
    logic [1:0]        cnt;

    at_max  = (position >= MAX_POS);
    idx     = at_max ? MAX_POS : position;
    ovf_now = overflow | at_max;
    n       = {1'b0, pend.count} + 3'd1;
    need    = (pend.count == 2'd0) ? seq_len(item.byte_value) : pend.need;
    hold    = !item.text_end && (n < need);
    back    = 3'd0;

    // working buffer: pending bytes then the new byte, zero beyond
    for (int k = 0; k < 8; k++) begin
      bufx[k] = 8'h00;
      offs[k] = '0;
    end
    for (int k = 0; k < PEND_DEPTH; k++) begin
      if (2'(k) < pend.count) begin
        bufx[k] = pend.bytes[k];
      end
    end
    bufx[{1'b0, pend.count}] = item.byte_value;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < n) begin
        back    = n - 3'd1 - 3'(k);
        offs[k] = (idx >= PW'(back)) ? idx - PW'(back) : '0;
      end
    end

    // walk at most three sequences through the buffer
    st  = 3'd0;
    cnt = 2'd0;
    for (int j = 0; j < MAX_RESULTS; j++) begin
      ok  = (st < n);
      len = seq_len(bufx[st]);
      if (({1'b0, st} + {1'b0, len}) > {1'b0, n}) begin
        len = 3'd1;
      end
      b = offs[st];
      e = {1'b0, offs[3'(st + len - 3'd1)]} + (PW+1)'(1);
      if (b > MAX_BEGIN) begin
        b = MAX_BEGIN;
      end
      if (e > MAX_END) begin
        e = MAX_END;
      end
      res[j].code_point      = seq_value(bufx[st], bufx[3'(st + 3'd1)],
                                         bufx[3'(st + 3'd2)], bufx[3'(st + 3'd3)], len);
      res[j].begin_offset    = 16'(32'(b));
      res[j].end_offset      = 17'(32'(e));
      res[j].last_of_run     = item.text_end &&
                               (({1'b0, st} + {1'b0, len}) >= {1'b0, n});
      res[j].offset_overflow = ovf_now;
      if (ok) begin
        cnt = cnt + 2'd1;
        st  = st + len;
      end
    end
    res_count = hold ? 2'd0 : cnt;

    // state for the next byte
    pend_next     = pend;
    position_next = at_max ? position : position + PW'(1);
    overflow_next = ovf_now;
    if (hold) begin
      pend_next.bytes[pend.count] = item.byte_value;
      pend_next.count             = n[1:0];
      pend_next.need              = need;
    end else begin
      pend_next.count = 2'd0;
      pend_next.need  = 3'd0;
      if (item.text_end) begin
        position_next = '0;
        overflow_next = 1'b0;
      end
    end
  end

endmodule

// ===== sv/u8ld_outq.sv =====
// four-entry result queue taking up to three results per cycle
`timescale 1ns / 1ps

module u8ld_outq (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [1:0]                                 push_count,
  input  u8ld_pkg::out_t [u8ld_pkg::MAX_RESULTS-1:0] push_data,
  output logic                                       room,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output u8ld_pkg::out_t                             out_data
);
  import u8ld_pkg::*;

  out_t       entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic       pop;

  assign out_valid = (fill != 3'd0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // a full flush needs three free slots
  assign room      = (fill <= 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + 2'(pop);
      fill   <= fill + 3'(push_count) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_RESULTS; j++) begin
      if (2'(j) < push_count) begin
        entries[2'(wr_ptr + 2'(j))] <= push_data[j];
      end
    end
  end

endmodule
